>>> hw/rtl/mstk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared sizes and types for the spanning tree core.
// ----------------------------------------------------------------------------
package mstk_pkg;

    localparam int MAX_NODES  = 64;
    localparam int MAX_EDGES  = 256;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int EDGE_AW    = $clog2(MAX_EDGES);
    localparam int CNT_W      = EDGE_AW + 1;
    localparam int NCFG_W     = 7;
    localparam int WEIGHT_W   = 32;
    localparam int TOTAL_W    = 40;
    localparam int RANK_W     = 3;

    // Input opcodes.
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // One stored edge word.
    typedef struct packed {
        logic [NODE_W-1:0]          from_node;
        logic [NODE_W-1:0]          to_node;
        logic signed [WEIGHT_W-1:0] weight;
    } t_edge;

    // Write request into the union-find store.
    typedef struct packed {
        logic              par_we;
        logic [NODE_W-1:0] par_addr;
        logic [NODE_W-1:0] par_data;
        logic              rank_we;
        logic [NODE_W-1:0] rank_addr;
        logic [RANK_W-1:0] rank_data;
    } t_uf_wr;

endpackage

>>> hw/rtl/mstk_edge_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstk_edge_mem
// Edge store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mstk_edge_mem (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [mstk_pkg::EDGE_AW-1:0] i_waddr,
    input  mstk_pkg::t_edge              i_wdata,
    input  logic [mstk_pkg::EDGE_AW-1:0] i_raddr,
    output mstk_pkg::t_edge              o_rdata
);

    mstk_pkg::t_edge r_mem [mstk_pkg::MAX_EDGES];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/mstk_uf_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstk_uf_mem
// Union-find store: parent and rank of each node, read together.
// ----------------------------------------------------------------------------
module mstk_uf_mem (
    input  logic                         i_clk,
    input  logic [mstk_pkg::NODE_W-1:0]  i_raddr,
    input  mstk_pkg::t_uf_wr             i_wr,
    output logic [mstk_pkg::NODE_W-1:0]  o_parent,
    output logic [mstk_pkg::RANK_W-1:0]  o_rank
);

    logic [mstk_pkg::NODE_W-1:0] r_par  [mstk_pkg::MAX_NODES];
    logic [mstk_pkg::RANK_W-1:0] r_rank [mstk_pkg::MAX_NODES];

    // Parent array.
    always_ff @(posedge i_clk) begin
        if (i_wr.par_we) begin
            r_par[i_wr.par_addr] <= i_wr.par_data;
        end
        o_parent <= r_par[i_raddr];
    end

    // Rank array.
    always_ff @(posedge i_clk) begin
        if (i_wr.rank_we) begin
            r_rank[i_wr.rank_addr] <= i_wr.rank_data;
        end
        o_rank <= r_rank[i_raddr];
    end

endmodule

>>> hw/rtl/minimum_spanning_tree_kruskal_core.sv
`timescale 1ns / 1ps
// Clear and add words are handled in S_IDLE; busy stays low for them.
// Compute: a union-find setup sweep over every node, then for each edge taken in weight order,
// tree edge or not, one scan of the store (a read and a compare per stored edge), a read and
// a check per node visited on each find path, and a join; the run ends with the summary word.
// Results are single-cycle o_strobe pulses; the receiver cannot stall.
// Reset: synchronous active low; clears edge count, overflow flag and node count.
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal_core
// Kruskal spanning tree over a loaded edge list using a union-find store.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_kruskal_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [1:0]                           i_opcode,
    input  logic [mstk_pkg::NODE_W-1:0]          i_from_node,
    input  logic [mstk_pkg::NODE_W-1:0]          i_to_node,
    input  logic signed [mstk_pkg::WEIGHT_W-1:0] i_weight,
    input  logic                                 i_cfg_we,
    input  logic [mstk_pkg::NCFG_W-1:0]          i_cfg_data,
    output logic                                 o_strobe,
    output logic                                 o_edge_valid,
    output logic [mstk_pkg::NODE_W-1:0]          o_tree_from,
    output logic [mstk_pkg::NODE_W-1:0]          o_tree_to,
    output logic signed [mstk_pkg::WEIGHT_W-1:0] o_edge_weight,
    output logic signed [mstk_pkg::TOTAL_W-1:0]  o_total_weight,
    output logic [mstk_pkg::NODE_W-1:0]          o_tree_edges,
    output logic                                 o_overflow,
    output logic                                 o_last
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_INIT = 10'b0000000010,
        S_SRD  = 10'b0000000100,
        S_SCMP = 10'b0000001000,
        S_PICK = 10'b0000010000,
        S_FRD  = 10'b0000100000,
        S_FCK  = 10'b0001000000,
        S_JOIN = 10'b0010000000,
        S_SUM  = 10'b0100000000,
        S_WAIT = 10'b1000000000
    } t_state;

    t_state                               r_state;
    logic [mstk_pkg::NCFG_W-1:0]          r_node_count;
    logic [mstk_pkg::CNT_W-1:0]           r_stored;
    logic                                 r_dropped;
    logic [mstk_pkg::CNT_W-1:0]           r_idx;
    logic                                 r_have_prev;
    logic signed [mstk_pkg::WEIGHT_W-1:0] r_prev_w;
    logic [mstk_pkg::EDGE_AW-1:0]         r_prev_i;
    logic                                 r_have_best;
    mstk_pkg::t_edge                      r_best;
    logic [mstk_pkg::EDGE_AW-1:0]         r_best_i;
    logic [mstk_pkg::NODE_W-1:0]          r_fx;
    logic                                 r_side;
    logic [mstk_pkg::NODE_W-1:0]          r_ra;
    logic [mstk_pkg::RANK_W-1:0]          r_rank_a;
    logic [mstk_pkg::NODE_W-1:0]          r_rb;
    logic [mstk_pkg::RANK_W-1:0]          r_rank_b;
    logic signed [mstk_pkg::TOTAL_W-1:0]  r_total;
    logic [mstk_pkg::NODE_W-1:0]          r_count;

    logic [mstk_pkg::NCFG_W-1:0]          n_use;
    logic                                 accept;
    logic                                 add_ok;
    mstk_pkg::t_edge                      rd_edge;
    mstk_pkg::t_edge                      wr_edge;
    logic [mstk_pkg::NODE_W-1:0]          uf_raddr;
    logic [mstk_pkg::NODE_W-1:0]          uf_parent;
    logic [mstk_pkg::RANK_W-1:0]          uf_rank;
    mstk_pkg::t_uf_wr                     uf_wr;
    logic                                 cand;
    logic [mstk_pkg::NCFG_W-1:0]          count_ext;

    assign o_busy  = (r_state != S_IDLE);
    assign accept  = i_start && !o_busy;
    assign n_use   = (r_node_count > mstk_pkg::NCFG_W'(mstk_pkg::MAX_NODES))
                   ? mstk_pkg::NCFG_W'(mstk_pkg::MAX_NODES) : r_node_count;
    assign add_ok  = (i_from_node < i_to_node)
                   && ({1'b0, i_to_node} < n_use);
    assign count_ext = {1'b0, r_count};

    assign wr_edge.from_node = i_from_node;
    assign wr_edge.to_node   = i_to_node;
    assign wr_edge.weight    = i_weight;

    mstk_edge_mem u_edge_mem (
        .i_clk   (i_clk),
        .i_we    (accept && (i_opcode == mstk_pkg::OP_ADD) && add_ok
                  && (r_stored < mstk_pkg::CNT_W'(mstk_pkg::MAX_EDGES))),
        .i_waddr (r_stored[mstk_pkg::EDGE_AW-1:0]),
        .i_wdata (wr_edge),
        .i_raddr (r_idx[mstk_pkg::EDGE_AW-1:0]),
        .o_rdata (rd_edge)
    );

    assign uf_raddr = r_fx;

    mstk_uf_mem u_uf_mem (
        .i_clk    (i_clk),
        .i_raddr  (uf_raddr),
        .i_wr     (uf_wr),
        .o_parent (uf_parent),
        .o_rank   (uf_rank)
    );

    // Key compare: usable edge, after the last pick, before the best so far.
    always_comb begin
        cand = ({1'b0, rd_edge.to_node} < n_use);
        if (r_have_prev) begin
            cand = cand && ((rd_edge.weight > r_prev_w)
                   || ((rd_edge.weight == r_prev_w)
                       && (r_idx[mstk_pkg::EDGE_AW-1:0] > r_prev_i)));
        end
        if (r_have_best) begin
            cand = cand && (rd_edge.weight < r_best.weight);
        end
    end

    // Union-find writes: setup sweep and union by rank.
    always_comb begin
        uf_wr = '0;
        if (r_state == S_INIT) begin
            uf_wr.par_we    = 1'b1;
            uf_wr.par_addr  = r_idx[mstk_pkg::NODE_W-1:0];
            uf_wr.par_data  = r_idx[mstk_pkg::NODE_W-1:0];
            uf_wr.rank_we   = 1'b1;
            uf_wr.rank_addr = r_idx[mstk_pkg::NODE_W-1:0];
            uf_wr.rank_data = '0;
        end else if ((r_state == S_JOIN) && (r_ra != r_rb)) begin
            uf_wr.par_we = 1'b1;
            if (r_rank_a < r_rank_b) begin
                uf_wr.par_addr = r_ra;
                uf_wr.par_data = r_rb;
            end else begin
                uf_wr.par_addr = r_rb;
                uf_wr.par_data = r_ra;
            end
            uf_wr.rank_we   = (r_rank_a == r_rank_b);
            uf_wr.rank_addr = r_ra;
            uf_wr.rank_data = r_rank_a + 1'b1;
        end
    end

    // Sequencer and load path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= '0;
            r_stored     <= '0;
            r_dropped    <= 1'b0;
            r_total      <= '0;
            r_count      <= '0;
            o_strobe     <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_opcode)
                            mstk_pkg::OP_CLEAR: begin
                                r_stored  <= '0;
                                r_dropped <= 1'b0;
                            end
                            mstk_pkg::OP_ADD: begin
                                if (add_ok) begin
                                    if (r_stored < mstk_pkg::CNT_W'(mstk_pkg::MAX_EDGES)) begin
                                        r_stored <= r_stored + 1'b1;
                                    end else begin
                                        r_dropped <= 1'b1;
                                    end
                                end
                            end
                            mstk_pkg::OP_COMPUTE: begin
                                r_total     <= '0;
                                r_count     <= '0;
                                r_idx       <= '0;
                                r_have_prev <= 1'b0;
                                r_have_best <= 1'b0;
                                r_state     <= S_INIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    if (r_idx == mstk_pkg::CNT_W'(mstk_pkg::MAX_NODES - 1)) begin
                        r_idx   <= '0;
                        r_state <= (n_use < 7'd2) ? S_SUM : S_SRD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SRD: begin
                    r_state <= (r_idx == r_stored) ? S_PICK : S_SCMP;
                end
                S_SCMP: begin
                    if (cand) begin
                        r_have_best <= 1'b1;
                        r_best      <= rd_edge;
                        r_best_i    <= r_idx[mstk_pkg::EDGE_AW-1:0];
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SRD;
                end
                S_PICK: begin
                    if (!r_have_best) begin
                        r_state <= S_SUM;
                    end else begin
                        r_have_prev <= 1'b1;
                        r_prev_w    <= r_best.weight;
                        r_prev_i    <= r_best_i;
                        r_fx        <= r_best.from_node;
                        r_side      <= 1'b0;
                        r_state     <= S_FRD;
                    end
                end
                S_FRD: begin
                    r_state <= S_FCK;
                end
                S_FCK: begin
                    if (uf_parent == r_fx) begin
                        if (!r_side) begin
                            r_ra     <= r_fx;
                            r_rank_a <= uf_rank;
                            r_fx     <= r_best.to_node;
                            r_side   <= 1'b1;
                            r_state  <= S_FRD;
                        end else begin
                            r_rb     <= r_fx;
                            r_rank_b <= uf_rank;
                            r_state  <= S_JOIN;
                        end
                    end else begin
                        r_fx    <= uf_parent;
                        r_state <= S_FRD;
                    end
                end
                S_JOIN: begin
                    r_idx       <= '0;
                    r_have_best <= 1'b0;
                    r_state     <= S_SRD;
                    if (r_ra != r_rb) begin
                        o_strobe       <= 1'b1;
                        o_edge_valid   <= 1'b1;
                        o_tree_from    <= r_best.from_node;
                        o_tree_to      <= r_best.to_node;
                        o_edge_weight  <= r_best.weight;
                        o_total_weight <= r_total + mstk_pkg::TOTAL_W'(r_best.weight);
                        o_tree_edges   <= r_count + 1'b1;
                        o_overflow     <= r_dropped;
                        o_last         <= 1'b0;
                        r_total        <= r_total + mstk_pkg::TOTAL_W'(r_best.weight);
                        r_count        <= r_count + 1'b1;
                        if (count_ext + 7'd2 == n_use) begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    o_strobe       <= 1'b1;
                    o_edge_valid   <= 1'b0;
                    o_tree_from    <= '0;
                    o_tree_to      <= '0;
                    o_edge_weight  <= '0;
                    o_total_weight <= r_total;
                    o_tree_edges   <= r_count;
                    o_overflow     <= r_dropped;
                    o_last         <= 1'b1;
                    r_state        <= S_WAIT;
                end
                S_WAIT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A tree edge word is never the last one, so the core is still busy.
    a_edge_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_edge_valid) |-> o_busy)
        else $error("tree edge shown while idle");

    // The summary word carries the last flag and no edge.
    a_sum_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !o_edge_valid)
        else $error("summary word marked as edge");

    // After the summary the core is free in the next cycle.
    a_sum_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_busy)
        else $error("core still busy after summary");

    // The scan index stays below the stored edge count during a compare.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP) |-> (r_idx < r_stored))
        else $error("scan ran past stored edges");
`endif

endmodule

>>> tb/tb_minimum_spanning_tree_kruskal_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_minimum_spanning_tree_kruskal_core
// Self-checking bench for the Kruskal spanning tree core. Edge, clear and
// compute words are sent with random gaps, except in the overflow test. A
// local union-find predictor builds the expected tree words, and each
// strobed word is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_minimum_spanning_tree_kruskal_core;

    localparam int OP_UNUSED  = 3;
    localparam int STALL_MAX  = 1000000;

    typedef struct {
        logic                                 edge_valid;
        logic [mstk_pkg::NODE_W-1:0]          tree_from;
        logic [mstk_pkg::NODE_W-1:0]          tree_to;
        logic signed [mstk_pkg::WEIGHT_W-1:0] edge_weight;
        logic signed [mstk_pkg::TOTAL_W-1:0]  total_weight;
        logic [mstk_pkg::NODE_W-1:0]          tree_edges;
        logic                                 overflow;
        logic                                 last;
    } t_tree_word;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_start = 1'b0;
    logic                                 o_busy;
    logic [1:0]                           i_opcode = mstk_pkg::OP_CLEAR;
    logic [mstk_pkg::NODE_W-1:0]          i_from_node = '0;
    logic [mstk_pkg::NODE_W-1:0]          i_to_node = '0;
    logic signed [mstk_pkg::WEIGHT_W-1:0] i_weight = '0;
    logic                                 i_cfg_we = 1'b0;
    logic [mstk_pkg::NCFG_W-1:0]          i_cfg_data = '0;
    logic                                 o_strobe;
    logic                                 o_edge_valid;
    logic [mstk_pkg::NODE_W-1:0]          o_tree_from;
    logic [mstk_pkg::NODE_W-1:0]          o_tree_to;
    logic signed [mstk_pkg::WEIGHT_W-1:0] o_edge_weight;
    logic signed [mstk_pkg::TOTAL_W-1:0]  o_total_weight;
    logic [mstk_pkg::NODE_W-1:0]          o_tree_edges;
    logic                                 o_overflow;
    logic                                 o_last;

    minimum_spanning_tree_kruskal_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic signed [mstk_pkg::WEIGHT_W-1:0] edge_w [mstk_pkg::MAX_EDGES];
    logic [mstk_pkg::NODE_W-1:0]          edge_a [mstk_pkg::MAX_EDGES];
    logic [mstk_pkg::NODE_W-1:0]          edge_b [mstk_pkg::MAX_EDGES];
    int                                   edge_cnt;
    logic                                 edge_dropped;
    int                                   uf_parent [mstk_pkg::MAX_NODES];
    int                                   uf_rank [mstk_pkg::MAX_NODES];
    int                                   sorted_idx [mstk_pkg::MAX_EDGES];
    int                                   node_cfg;

    t_tree_word tree_words_q[$];
    int         fail_cnt;
    int         stall_cnt;
    bit         gaps_on;

    function automatic int nodes_used();
        return (node_cfg > mstk_pkg::MAX_NODES) ? mstk_pkg::MAX_NODES : node_cfg;
    endfunction

    function automatic int uf_root(int x);
        int r;
        int nx;
        r = x;
        while (uf_parent[r] != r) r = uf_parent[r];
        while (uf_parent[x] != r) begin
            nx = uf_parent[x];
            uf_parent[x] = r;
            x = nx;
        end
        return r;
    endfunction

    function automatic bit uf_join(int a, int b);
        int ra;
        int rb;
        ra = uf_root(a);
        rb = uf_root(b);
        if (ra == rb) return 1'b0;
        if (uf_rank[ra] < uf_rank[rb]) begin
            uf_parent[ra] = rb;
        end else if (uf_rank[ra] > uf_rank[rb]) begin
            uf_parent[rb] = ra;
        end else begin
            uf_parent[rb] = ra;
            uf_rank[ra]++;
        end
        return 1'b1;
    endfunction

    // Builds the expected tree words for one compute.
    task automatic predict_tree();
        int n;
        int j;
        int e;
        int chosen;
        logic signed [mstk_pkg::TOTAL_W-1:0] total;
        t_tree_word tw;
        n = nodes_used();
        chosen = 0;
        total = '0;
        for (int i = 0; i < edge_cnt; i++) begin
            j = i;
            while (j > 0 && edge_w[sorted_idx[j-1]] > edge_w[i]) begin
                sorted_idx[j] = sorted_idx[j-1];
                j--;
            end
            sorted_idx[j] = i;
        end
        for (int i = 0; i < mstk_pkg::MAX_NODES; i++) begin
            uf_parent[i] = i;
            uf_rank[i] = 0;
        end
        if (n >= 2) begin
            for (int i = 0; i < edge_cnt; i++) begin
                e = sorted_idx[i];
                if (chosen >= n - 1) break;
                if (edge_b[e] >= n || edge_a[e] >= edge_b[e]) continue;
                if (uf_join(edge_a[e], edge_b[e])) begin
                    total += edge_w[e];
                    chosen++;
                    tw = '{1'b1, edge_a[e], edge_b[e], edge_w[e], total,
                           mstk_pkg::NODE_W'(chosen), edge_dropped, 1'b0};
                    tree_words_q.push_back(tw);
                end
            end
        end
        tw = '{1'b0, '0, '0, '0, total, mstk_pkg::NODE_W'(chosen), edge_dropped, 1'b1};
        tree_words_q.push_back(tw);
    endtask

    task automatic predict_word(logic [1:0] op, logic [mstk_pkg::NODE_W-1:0] a,
                                logic [mstk_pkg::NODE_W-1:0] b,
                                logic signed [mstk_pkg::WEIGHT_W-1:0] w);
        if (op == mstk_pkg::OP_CLEAR) begin
            edge_cnt = 0;
            edge_dropped = 1'b0;
        end else if (op == mstk_pkg::OP_ADD) begin
            if (a < b && b < nodes_used()) begin
                if (edge_cnt >= mstk_pkg::MAX_EDGES) begin
                    edge_dropped = 1'b1;
                end else begin
                    edge_w[edge_cnt] = w;
                    edge_a[edge_cnt] = a;
                    edge_b[edge_cnt] = b;
                    edge_cnt++;
                end
            end
        end else if (op == mstk_pkg::OP_COMPUTE) begin
            predict_tree();
        end
    endtask

    // Sends one word; start stays high so a following word can go back to back.
    task automatic send_word(logic [1:0] op, logic [mstk_pkg::NODE_W-1:0] a,
                             logic [mstk_pkg::NODE_W-1:0] b,
                             logic signed [mstk_pkg::WEIGHT_W-1:0] w);
        if (gaps_on && $urandom_range(99) < 6) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_opcode    <= op;
        i_from_node <= a;
        i_to_node   <= b;
        i_weight    <= w;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_word(op, a, b, w);
    endtask

    // Lowers start and waits until every expected word has arrived.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (tree_words_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_node_count(int value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mstk_pkg::NCFG_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        node_cfg = value & 7'h7f;
        @(posedge i_clk);
    endtask

    task automatic add_random_edge(int n);
        int a;
        int b;
        logic signed [mstk_pkg::WEIGHT_W-1:0] w;
        if (n < 2) n = 2;
        a = $urandom_range(n - 2);
        b = $urandom_range(n - 1, a + 1);
        w = ($urandom_range(3) == 0) ? mstk_pkg::WEIGHT_W'($urandom_range(3)) : $urandom;
        send_word(mstk_pkg::OP_ADD, a, b, w);
    endtask

    // Extremes of every field, ignored adds and the unused opcode.
    task automatic test_directed();
        write_node_count(0);
        send_word(mstk_pkg::OP_ADD, 0, 1, 32'sd5);
        send_word(mstk_pkg::OP_COMPUTE, 0, 0, 0);
        write_node_count(1);
        send_word(mstk_pkg::OP_COMPUTE, 0, 0, 0);
        write_node_count(64);
        send_word(mstk_pkg::OP_CLEAR, 0, 0, 0);
        send_word(mstk_pkg::OP_ADD, 0, 63, 32'sh7fffffff);
        send_word(mstk_pkg::OP_ADD, 0, 1, 32'sh80000000);
        send_word(mstk_pkg::OP_ADD, 1, 2, 32'sh80000000);
        send_word(mstk_pkg::OP_ADD, 0, 2, 32'sh80000000);
        send_word(mstk_pkg::OP_ADD, 5, 5, 32'sd1);
        send_word(mstk_pkg::OP_ADD, 3, 2, 32'sd1);
        send_word(mstk_pkg::OP_ADD, 62, 63, 32'sh0000ffff);
        send_word(2'(OP_UNUSED), 63, 63, 32'shffffffff);
        send_word(mstk_pkg::OP_COMPUTE, 63, 63, 32'shffffffff);
        send_word(mstk_pkg::OP_CLEAR, 63, 0, 32'sd1);
        send_word(mstk_pkg::OP_COMPUTE, 0, 0, 0);
        write_node_count(127);
        send_word(mstk_pkg::OP_ADD, 10, 63, -32'sd7);
        send_word(mstk_pkg::OP_ADD, 2, 10, -32'sd7);
        send_word(mstk_pkg::OP_COMPUTE, 0, 0, 0);
    endtask

    // Edges loaded under a large node count, then computed under a smaller one.
    task automatic test_node_count_lowered();
        write_node_count(64);
        send_word(mstk_pkg::OP_CLEAR, 0, 0, 0);
        repeat (10) add_random_edge(64);
        write_node_count(12);
        send_word(mstk_pkg::OP_COMPUTE, 0, 0, 0);
        write_node_count(2);
        send_word(mstk_pkg::OP_COMPUTE, 0, 0, 0);
    endtask

    // Full store, sticky overflow, and the clear that drops it; sent with no gaps.
    task automatic test_overflow();
        write_node_count(64);
        gaps_on = 1'b0;
        send_word(mstk_pkg::OP_CLEAR, 0, 0, 0);
        repeat (mstk_pkg::MAX_EDGES + 1) add_random_edge(64);
        send_word(mstk_pkg::OP_COMPUTE, 0, 0, 0);
        send_word(mstk_pkg::OP_CLEAR, 0, 0, 0);
        send_word(mstk_pkg::OP_COMPUTE, 0, 0, 0);
        gaps_on = 1'b1;
    endtask

    // Random graphs: mostly well formed loads, some noise words.
    task automatic test_random(int items);
        int sent;
        int n;
        int k;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(9))
                0: n = $urandom_range(1);
                1: n = $urandom_range(127, 64);
                2: n = 64;
                default: n = $urandom_range(16, 2);
            endcase
            write_node_count(n);
            send_word(mstk_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
            k = $urandom_range(16);
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(7) == 0) begin
                    send_word(2'($urandom_range(3) == 0 ? OP_UNUSED : mstk_pkg::OP_ADD),
                              $urandom, $urandom, $urandom);
                end else begin
                    add_random_edge(n > mstk_pkg::MAX_NODES ? mstk_pkg::MAX_NODES : n);
                end
            end
            send_word(mstk_pkg::OP_COMPUTE, $urandom, $urandom, $urandom);
            sent += k + 2;
        end
    endtask

    // Compares each strobed word with the oldest expected one.
    always @(posedge i_clk) begin
        t_tree_word exp_w;
        if (i_rst_n && o_strobe) begin
            if (tree_words_q.size() == 0) begin
                $error("unexpected word: edge_valid %0d last %0d", o_edge_valid, o_last);
                fail_cnt++;
            end else begin
                exp_w = tree_words_q.pop_front();
                if (o_edge_valid !== exp_w.edge_valid) begin
                    $error("edge_valid exp %0d got %0d", exp_w.edge_valid, o_edge_valid);
                    fail_cnt++;
                end
                if (o_tree_from !== exp_w.tree_from) begin
                    $error("tree_from exp %0d got %0d", exp_w.tree_from, o_tree_from);
                    fail_cnt++;
                end
                if (o_tree_to !== exp_w.tree_to) begin
                    $error("tree_to exp %0d got %0d", exp_w.tree_to, o_tree_to);
                    fail_cnt++;
                end
                if (o_edge_weight !== exp_w.edge_weight) begin
                    $error("edge_weight exp %0d got %0d", exp_w.edge_weight, o_edge_weight);
                    fail_cnt++;
                end
                if (o_total_weight !== exp_w.total_weight) begin
                    $error("total_weight exp %0d got %0d", exp_w.total_weight,
                           o_total_weight);
                    fail_cnt++;
                end
                if (o_tree_edges !== exp_w.tree_edges) begin
                    $error("tree_edges exp %0d got %0d", exp_w.tree_edges, o_tree_edges);
                    fail_cnt++;
                end
                if (o_overflow !== exp_w.overflow) begin
                    $error("overflow exp %0d got %0d", exp_w.overflow, o_overflow);
                    fail_cnt++;
                end
                if (o_last !== exp_w.last) begin
                    $error("last exp %0d got %0d", exp_w.last, o_last);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves either way.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (i_start && !o_busy) || i_cfg_we) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        fail_cnt = 0;
        stall_cnt = 0;
        edge_cnt = 0;
        edge_dropped = 1'b0;
        node_cfg = 0;
        gaps_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_node_count_lowered();
        test_overflow();
        test_random(8);
        drain();
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0 && tree_words_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/mstk_pkg.sv
hw/rtl/mstk_edge_mem.sv
hw/rtl/mstk_uf_mem.sv
hw/rtl/minimum_spanning_tree_kruskal_core.sv
tb/tb_minimum_spanning_tree_kruskal_core.sv
